### rtl/sha256_message_hasher_assert.svh
// Assertion macros shared by the SHA-256 front end and compression engine.
`ifndef SHA256_MESSAGE_HASHER_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SHA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and the front-to-back command type.
// ----------------------------------------------------------------------------
package sha_pkg;

	// Command passed from the byte front end to the compression engine.
	typedef struct packed {
		logic [511:0] block;
		logic         final_blk;
	} sha_cmd_t;

	localparam int QDepth = 2;

	// Initial chaining value, H0 in the top word.
	localparam logic [255:0] InitialHash = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
		32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k;
		begin
			unique case (t)
				6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
				6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
				6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
				6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
				6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
				6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
				6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
				6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
				6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
				6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
				6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
				6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
				6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
				6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
				6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
				6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
				6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
				6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
				6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
				6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
				6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
				default: k = 32'hc67178f2;
			endcase
			return k;
		end
	endfunction

endpackage

### rtl/sha256_message_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Byte-stream SHA-256 with a byte front end, a block queue and a round engine.
// ----------------------------------------------------------------------------
// Bytes enter one per cycle until a 64-byte block is full; the front end then
// holds the input while it hands the block to a two-entry queue, and keeps
// loading while the engine runs. The engine loads a block, runs 64 rounds at
// one round a cycle and adds the result into the chaining state, so the
// sustained rate is set by the round loop; the input also stalls whenever the
// queue is full. An end item holds the input while one or two padded blocks
// are built and queued, and the eight digest words follow on the output, H0
// first, one per accepted output item.
module sha256_message_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // msg_byte[7:0]
	input  logic        s_tuser,  // has_byte
	input  logic        s_tlast,  // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // digest_word[31:0], word_index[34:32], zero fill
	output logic        m_tlast   // last_word
);
	import sha_pkg::*;

	sha_cmd_t   f_cmd, q_cmd;
	logic       f_valid, f_ready, q_valid, q_ready;
	logic [31:0] word;
	logic [2:0]  index;

	sha_front u_front (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_byte(s_tdata), .in_has(s_tuser), .in_end(s_tlast),
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	sha_queue u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_cmd(f_cmd),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_cmd(q_cmd)
	);

	sha_engine u_engine (
		.clk, .arst_n,
		.cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_word(word), .out_index(index), .out_last(m_tlast)
	);

	assign m_tdata = {5'd0, index, word};
endmodule

### rtl/sha_front.sv
// ----------------------------------------------------------------------------
// SHA-256 byte front end
// Packs bytes into 512-bit blocks, counts the bit length and builds the
// padding blocks, handing each complete block to the command queue.
// ----------------------------------------------------------------------------
module sha_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              in_has,
	input  logic              in_end,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output sha_pkg::sha_cmd_t cmd
);
	import sha_pkg::*;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_FULL,
		ST_PAD,
		ST_LEN
	} front_state_t;

	front_state_t state_q;
	logic [511:0] blk_q;
	logic [5:0]   pos_q;
	logic [63:0]  len_q;
	logic         pend_end_q;
	logic         spill_q;

	logic [511:0] blk_byte;
	logic [511:0] blk_pad;
	logic [5:0]   pos_inc;

	// Byte placed big-endian at the current position.
	always_comb begin
		blk_byte = blk_q;
		blk_byte[10'd511 - {1'b0, pos_q, 3'd0} -: 8] = in_byte;
		pos_inc = pos_q + 6'd1;
	end

	// Marker byte at the current position, zeros after it, and the length
	// in the last eight bytes when it still fits.
	always_comb begin
		blk_pad = blk_q;
		for (int i = 0; i < 64; i++) begin
			if (6'(i) == pos_q) blk_pad[511 - 8*i -: 8] = 8'h80;
			else if (6'(i) > pos_q) blk_pad[511 - 8*i -: 8] = 8'h00;
		end
		if (pos_q < 6'd56) blk_pad[63:0] = len_q;
	end

	assign in_ready = (state_q == ST_LOAD);

	always_comb begin
		cmd_valid = (state_q == ST_FULL) || (state_q == ST_LEN);
		cmd.block = blk_q;
		cmd.final_blk = (state_q == ST_LEN);
	end

	// Front sequencer: load bytes, then issue full and padding blocks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			blk_q <= '0;
			pos_q <= '0;
			len_q <= '0;
			pend_end_q <= 1'b0;
			spill_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_valid) begin
						if (in_has) begin
							blk_q <= blk_byte;
							pos_q <= pos_inc;
							len_q <= len_q + 64'd8;
							if (pos_inc == 6'd0) begin
								state_q <= ST_FULL;
								pend_end_q <= in_end;
							end else if (in_end) begin
								state_q <= ST_PAD;
							end
						end else if (in_end) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_FULL: begin
					if (cmd_ready) begin
						// After a spill-over block the last block holds only the length.
						if (spill_q) begin
							blk_q <= {448'd0, len_q};
							spill_q <= 1'b0;
							state_q <= ST_LEN;
						end else begin
							state_q <= pend_end_q ? ST_PAD : ST_LOAD;
						end
						pend_end_q <= 1'b0;
					end
				end
				ST_PAD: begin
					blk_q <= blk_pad;
					if (pos_q < 6'd56) begin
						state_q <= ST_LEN;
					end else begin
						state_q <= ST_FULL;
						pos_q <= '0;
						spill_q <= 1'b1;
					end
				end
				ST_LEN: begin
					if (cmd_ready) begin
						state_q <= ST_LOAD;
						pos_q <= '0;
						len_q <= '0;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	`include "sha256_message_hasher_assert.svh"
	`SHA_ASSERT_IMP(a_len_final, cmd_valid && cmd.final_blk, pos_q < 6'd56, "final block position")
	`SHA_ASSERT_NEXT(a_full_hold, cmd_valid && !cmd_ready, cmd_valid, "command dropped")
	`SHA_ASSERT_IMP(a_no_in, cmd_valid, !in_ready, "input taken while block pending")
endmodule

### rtl/sha_queue.sv
// ----------------------------------------------------------------------------
// SHA-256 command queue
// Short FIFO of block commands between the front end and the engine.
// ----------------------------------------------------------------------------
module sha_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_ready,
	input  sha_pkg::sha_cmd_t wr_cmd,
	output logic              rd_valid,
	input  logic              rd_ready,
	output sha_pkg::sha_cmd_t rd_cmd
);
	import sha_pkg::*;

	sha_cmd_t   mem_q [QDepth];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign wr_ready = (cnt_q != 2'(QDepth));
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_cmd = mem_q[rp_q];

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr_valid && wr_ready) wp_q <= ~wp_q;
			if (rd_valid && rd_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) mem_q[wp_q] <= wr_cmd;
	end
endmodule

### rtl/sha_engine.sv
// ----------------------------------------------------------------------------
// SHA-256 compression engine
// Runs 64 rounds per block, one round a cycle, folds the result into the
// chaining state and emits eight digest words after a final block.
// ----------------------------------------------------------------------------
module sha_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  sha_pkg::sha_cmd_t cmd,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       out_word,
	output logic [2:0]        out_index,
	output logic              out_last
);
	import sha_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} eng_state_t;

	eng_state_t   state_q;
	logic [255:0] hash_q;
	logic [255:0] vars_q;
	logic [511:0] win_q;
	logic [5:0]   rnd_q;
	logic         fin_q;
	logic [2:0]   idx_q;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	logic [31:0] a, b, c, d, e, f, g, h, w, t1, t2, wn, w1, w14;

	// One round and the next schedule word.
	always_comb begin
		{a, b, c, d, e, f, g, h} = vars_q;
		w = win_q[511 -: 32];
		w1 = win_q[479 -: 32];
		w14 = win_q[63 -: 32];
		wn = (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10)) + win_q[223 -: 32]
			+ (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3)) + w;
		t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
			+ round_k(rnd_q) + w;
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
	end

	assign cmd_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign out_word = hash_q[255 -: 32];
	assign out_index = idx_q;
	assign out_last = (idx_q == 3'd7);

	// Engine sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hash_q <= InitialHash;
			vars_q <= '0;
			win_q <= '0;
			rnd_q <= '0;
			fin_q <= 1'b0;
			idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						win_q <= cmd.block;
						vars_q <= hash_q;
						fin_q <= cmd.final_blk;
						rnd_q <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					vars_q <= {t1 + t2, a, b, c, d + t1, e, f, g};
					win_q <= {win_q[479:0], wn};
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++)
						hash_q[255 - 32*i -: 32] <= hash_q[255 - 32*i -: 32] + vars_q[255 - 32*i -: 32];
					idx_q <= '0;
					state_q <= fin_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (out_ready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							hash_q <= InitialHash;
							state_q <= ST_IDLE;
						end else begin
							hash_q <= {hash_q[223:0], 32'd0};
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`include "sha256_message_hasher_assert.svh"
	`SHA_ASSERT_IMP(a_idle_round, state_q == ST_ROUND, !cmd_ready, "engine busy accept")
	`SHA_ASSERT_NEXT(a_last_wrap, out_valid && out_ready && out_last, state_q == ST_IDLE, "emit end")
	`SHA_ASSERT_IMP(a_emit_fin, out_valid, fin_q, "digest without final block")
endmodule
